[src/hfl_pkg.sv]
// Package for the hysteresis fan and light controller.
// Holds field widths, register reset values, register index codes and fan level codes.
// No dependencies.
package hfl_pkg;

  localparam int TEMP_W   = 16;
  localparam int BAND_W   = 15;
  localparam int SENSE_W  = 16;
  localparam int TICK_W   = 32;
  localparam int LEVEL_W  = 8;
  localparam int FAN_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [TEMP_W-1:0] TEMP_ON_RESET       = 16'sd7168;
  localparam logic signed [TEMP_W-1:0] TEMP_MEDIUM_RESET   = 16'sd7680;
  localparam logic signed [TEMP_W-1:0] TEMP_CRITICAL_RESET = 16'sd8960;
  localparam logic [BAND_W-1:0]        TEMP_BAND_RESET     = 15'd512;
  localparam logic [SENSE_W-1:0]       DARK_LEVEL_RESET    = 16'd100;
  localparam logic [SENSE_W-1:0]       LIGHT_BAND_RESET    = 16'd50;
  localparam logic [SENSE_W-1:0]       SMOKE_LIMIT_RESET   = 16'd2000;
  localparam logic [TICK_W-1:0]        BEEP_INTERVAL_RESET = 32'd10000;

  localparam int LED_FULL_LEVEL_DEFAULT = 255;
  localparam bit AUTO_FAN_ON_DEFAULT    = 1'b1;
  localparam bit AUTO_LIGHT_ON_DEFAULT  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_ON       = 3'd0,
    REG_TEMP_MEDIUM   = 3'd1,
    REG_TEMP_CRITICAL = 3'd2,
    REG_TEMP_BAND     = 3'd3,
    REG_DARK_LEVEL    = 3'd4,
    REG_LIGHT_BAND    = 3'd5,
    REG_SMOKE_LIMIT   = 3'd6,
    REG_BEEP_INTERVAL = 3'd7
  } cfg_reg_t;

  typedef enum logic [FAN_W-1:0] {
    FAN_OFF    = 2'd0,
    FAN_LOW    = 2'd1,
    FAN_MEDIUM = 2'd2,
    FAN_HIGH   = 2'd3
  } fan_level_t;

  // Result item as held in the output register.
  typedef struct packed {
    logic [FAN_W-1:0]   fan_level;
    logic               fan_run;
    logic               led_run;
    logic [LEVEL_W-1:0] led_level;
    logic               beep;
    logic               alarm;
    logic               curtain_move;
    logic               curtain_position;
  } result_t;

endpackage

[src/hysteresis_fan_light_controller.sv]
// Hysteresis fan and light controller with smoke alarm, top level.
// Each result passes through the input register and then the result register.
// Throughput: one item per cycle while results drain; the state latches update as an item
// enters the result register, so the next item in the input register already sees them.
// Reset (rst, synchronous, active high): latches, beep tick and curtain clear, registers
// take their reset values, both pipeline stages empty.
module hysteresis_fan_light_controller #(
  parameter int LED_FULL_LEVEL = hfl_pkg::LED_FULL_LEVEL_DEFAULT,
  parameter bit AUTO_FAN_ON    = hfl_pkg::AUTO_FAN_ON_DEFAULT,
  parameter bit AUTO_LIGHT_ON  = hfl_pkg::AUTO_LIGHT_ON_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_write_enable,
  input  logic [hfl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hfl_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input item channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                kind,
  input  logic signed [hfl_pkg::TEMP_W-1:0]   temperature,
  input  logic [hfl_pkg::SENSE_W-1:0]         light,
  input  logic [hfl_pkg::SENSE_W-1:0]         smoke,
  input  logic [hfl_pkg::TICK_W-1:0]          now_tick,
  input  logic                                auto_mode,
  input  logic [hfl_pkg::FAN_W-1:0]           user_fan_level,
  input  logic                                user_fan_on,
  input  logic                                user_led_on,
  input  logic [hfl_pkg::LEVEL_W-1:0]         user_led_level,
  input  logic                                curtain_request,
  // result item channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hfl_pkg::FAN_W-1:0]           fan_level,
  output logic                                fan_run,
  output logic                                led_run,
  output logic [hfl_pkg::LEVEL_W-1:0]         led_level,
  output logic                                beep,
  output logic                                alarm,
  output logic                                curtain_move,
  output logic                                curtain_position
);

  import hfl_pkg::*;

  localparam logic [LEVEL_W-1:0] LED_FULL = LEVEL_W'(LED_FULL_LEVEL);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [TEMP_W-1:0] temp_on_level;
  logic signed [TEMP_W-1:0] temp_medium_level;
  logic signed [TEMP_W-1:0] temp_critical_level;
  logic [BAND_W-1:0]        temp_band;
  logic [SENSE_W-1:0]       dark_level;
  logic [SENSE_W-1:0]       light_band;
  logic [SENSE_W-1:0]       smoke_limit;
  logic [TICK_W-1:0]        beep_interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_on_level       <= TEMP_ON_RESET;
      temp_medium_level   <= TEMP_MEDIUM_RESET;
      temp_critical_level <= TEMP_CRITICAL_RESET;
      temp_band           <= TEMP_BAND_RESET;
      dark_level          <= DARK_LEVEL_RESET;
      light_band          <= LIGHT_BAND_RESET;
      smoke_limit         <= SMOKE_LIMIT_RESET;
      beep_interval       <= BEEP_INTERVAL_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_reg_t'(cfg_index))
        REG_TEMP_ON:       temp_on_level       <= signed'(cfg_data[TEMP_W-1:0]);
        REG_TEMP_MEDIUM:   temp_medium_level   <= signed'(cfg_data[TEMP_W-1:0]);
        REG_TEMP_CRITICAL: temp_critical_level <= signed'(cfg_data[TEMP_W-1:0]);
        REG_TEMP_BAND:     temp_band           <= cfg_data[BAND_W-1:0];
        REG_DARK_LEVEL:    dark_level          <= cfg_data[SENSE_W-1:0];
        REG_LIGHT_BAND:    light_band          <= cfg_data[SENSE_W-1:0];
        REG_SMOKE_LIMIT:   smoke_limit         <= cfg_data[SENSE_W-1:0];
        REG_BEEP_INTERVAL: beep_interval       <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register (s1) feeds the result register.
  // s1 advances whenever the result register is empty or being drained; a result
  // that waits holds s1, and once s1 is full the input stalls too.
  // ---------------------------------------------------------------------------
  logic s1_valid;
  logic s1_advance;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Input payload register, no reset needed.
  logic                     s1_kind;
  logic signed [TEMP_W-1:0] s1_temperature;
  logic [SENSE_W-1:0]       s1_light;
  logic [SENSE_W-1:0]       s1_smoke;
  logic [TICK_W-1:0]        s1_now_tick;
  logic                     s1_auto_mode;
  logic [FAN_W-1:0]         s1_user_fan_level;
  logic                     s1_user_fan_on;
  logic                     s1_user_led_on;
  logic [LEVEL_W-1:0]       s1_user_led_level;
  logic                     s1_curtain_request;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind            <= kind;
      s1_temperature     <= temperature;
      s1_light           <= light;
      s1_smoke           <= smoke;
      s1_now_tick        <= now_tick;
      s1_auto_mode       <= auto_mode;
      s1_user_fan_level  <= user_fan_level;
      s1_user_fan_on     <= user_fan_on;
      s1_user_led_on     <= user_led_on;
      s1_user_led_level  <= user_led_level;
      s1_curtain_request <= curtain_request;
    end
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  logic              fan_latched,   fan_latched_next;
  logic              led_latched,   led_latched_next;
  logic              alarm_latched, alarm_latched_next;
  logic [TICK_W-1:0] last_beep_tick, last_beep_tick_next;
  logic              last_curtain,  last_curtain_next;

  // Thresholds formed wider than their operands so they never wrap.
  logic signed [TEMP_W+1:0] temp_off_level;
  logic signed [TEMP_W+1:0] temp_wide;
  logic [SENSE_W:0]         light_off_level;
  logic [TICK_W-1:0]        tick_gap;
  logic                     smoke_hit;

  assign temp_off_level  = (TEMP_W+2)'(temp_on_level) - signed'({3'b000, temp_band});
  assign temp_wide       = (TEMP_W+2)'(s1_temperature);
  assign light_off_level = {1'b0, dark_level} + {1'b0, light_band};
  assign tick_gap        = s1_now_tick - last_beep_tick;  // modulo 2^32 by width
  assign smoke_hit       = s1_smoke > smoke_limit;

  result_t res_next;
  result_t res;

  always_comb begin
    fan_latched_next    = fan_latched;
    led_latched_next    = led_latched;
    alarm_latched_next  = alarm_latched;
    last_beep_tick_next = last_beep_tick;
    last_curtain_next   = last_curtain;

    res_next.fan_level        = s1_user_fan_level;
    res_next.fan_run          = s1_user_fan_on;
    res_next.led_run          = s1_user_led_on;
    res_next.led_level        = s1_user_led_level;
    res_next.beep             = 1'b0;
    res_next.alarm            = 1'b0;
    res_next.curtain_move     = 1'b0;
    res_next.curtain_position = 1'b0;

    if (s1_kind) begin
      // set mode: in auto mode, resync hysteresis latches from the user flags
      if (s1_auto_mode) begin
        fan_latched_next = s1_user_fan_on;
        led_latched_next = s1_user_led_on;
      end
    end else begin
      if (smoke_hit) begin
        if (!alarm_latched) begin
          alarm_latched_next = 1'b1;
          res_next.beep      = 1'b1;
        end else if (tick_gap >= beep_interval) begin
          res_next.beep = 1'b1;
        end
        if (res_next.beep) begin
          last_beep_tick_next = s1_now_tick;
        end
        res_next.fan_level = FAN_HIGH;
        res_next.fan_run   = 1'b1;
        fan_latched_next   = 1'b1;
      end else begin
        alarm_latched_next = 1'b0;
        if (s1_auto_mode && AUTO_FAN_ON) begin
          if (fan_latched) begin
            if (temp_wide < temp_off_level) begin
              res_next.fan_level = FAN_OFF;
              res_next.fan_run   = 1'b0;
              fan_latched_next   = 1'b0;
            end else if (s1_temperature > temp_critical_level) begin
              res_next.fan_level = FAN_HIGH;
              res_next.fan_run   = 1'b1;
            end else if (s1_temperature > temp_medium_level) begin
              res_next.fan_level = FAN_MEDIUM;
              res_next.fan_run   = 1'b1;
            end else begin
              res_next.fan_level = FAN_LOW;
              res_next.fan_run   = 1'b1;
            end
          end else begin
            if (s1_temperature > temp_critical_level) begin
              res_next.fan_level = FAN_HIGH;
              res_next.fan_run   = 1'b1;
              fan_latched_next   = 1'b1;
            end else if (s1_temperature > temp_medium_level) begin
              res_next.fan_level = FAN_MEDIUM;
              res_next.fan_run   = 1'b1;
              fan_latched_next   = 1'b1;
            end else if (s1_temperature > temp_on_level) begin
              res_next.fan_level = FAN_LOW;
              res_next.fan_run   = 1'b1;
              fan_latched_next   = 1'b1;
            end else begin
              res_next.fan_level = FAN_OFF;
              res_next.fan_run   = 1'b0;
            end
          end
        end
      end

      // light hysteresis runs whether or not the alarm is active
      if (s1_auto_mode && AUTO_LIGHT_ON) begin
        if (led_latched) begin
          if ({1'b0, s1_light} > light_off_level) begin
            res_next.led_run   = 1'b0;
            res_next.led_level = '0;
            led_latched_next   = 1'b0;
          end
        end else if (s1_light < dark_level) begin
          res_next.led_run   = 1'b1;
          res_next.led_level = LED_FULL;
          led_latched_next   = 1'b1;
        end
      end

      if (s1_curtain_request != last_curtain) begin
        res_next.curtain_move = 1'b1;
        last_curtain_next     = s1_curtain_request;
      end
    end

    if (!res_next.led_run) begin
      res_next.led_level = '0;
    end
    res_next.alarm            = alarm_latched_next;
    res_next.curtain_position = last_curtain_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fan_latched    <= 1'b0;
      led_latched    <= 1'b0;
      alarm_latched  <= 1'b0;
      last_beep_tick <= '0;
      last_curtain   <= 1'b0;
    end else if (s1_advance) begin
      fan_latched    <= fan_latched_next;
      led_latched    <= led_latched_next;
      alarm_latched  <= alarm_latched_next;
      last_beep_tick <= last_beep_tick_next;
      last_curtain   <= last_curtain_next;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res <= res_next;
    end
  end

  assign fan_level        = res.fan_level;
  assign fan_run          = res.fan_run;
  assign led_run          = res.led_run;
  assign led_level        = res.led_level;
  assign beep             = res.beep;
  assign alarm            = res.alarm;
  assign curtain_move     = res.curtain_move;
  assign curtain_position = res.curtain_position;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Testbench for hysteresis_fan_light_controller: random and directed sensor items,
// checked against an in-bench model of the alarm, fan and light hysteresis latches.
// Depends on hfl_pkg and the controller top level only.
module tb;
  import hfl_pkg::*;

  localparam int HOLD_CYCLES  = 80;   // long receiver hold-off, fills the pipeline
  localparam int STUCK_LIMIT  = 1000; // cycles with no handshake before giving up
  localparam int TAIL_CYCLES  = 4;    // two pipeline stages plus margin
  localparam int PHASES       = 8;
  localparam int RANDOM_ITEMS = 62;   // per phase
  localparam int PRINT_CAP    = 40;

  typedef enum logic {
    KIND_SAMPLE   = 1'b0,
    KIND_SET_MODE = 1'b1
  } item_kind_t;

  // One input item, same order as the ports.
  typedef struct packed {
    item_kind_t                 kind;
    logic signed [TEMP_W-1:0]   temperature;
    logic [SENSE_W-1:0]         light;
    logic [SENSE_W-1:0]         smoke;
    logic [TICK_W-1:0]          now_tick;
    logic                       auto_mode;
    logic [FAN_W-1:0]           user_fan_level;
    logic                       user_fan_on;
    logic                       user_led_on;
    logic [LEVEL_W-1:0]         user_led_level;
    logic                       curtain_request;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_write_enable = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic    in_valid = 1'b0;
  logic    in_ready;
  sample_t cur_item = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FAN_W-1:0]   fan_level;
  logic               fan_run;
  logic               led_run;
  logic [LEVEL_W-1:0] led_level;
  logic               beep;
  logic               alarm;
  logic               curtain_move;
  logic               curtain_position;

  hysteresis_fan_light_controller dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (cur_item.kind),
    .temperature      (cur_item.temperature),
    .light            (cur_item.light),
    .smoke            (cur_item.smoke),
    .now_tick         (cur_item.now_tick),
    .auto_mode        (cur_item.auto_mode),
    .user_fan_level   (cur_item.user_fan_level),
    .user_fan_on      (cur_item.user_fan_on),
    .user_led_on      (cur_item.user_led_on),
    .user_led_level   (cur_item.user_led_level),
    .curtain_request  (cur_item.curtain_request),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .fan_level        (fan_level),
    .fan_run          (fan_run),
    .led_run          (led_run),
    .led_level        (led_level),
    .beep             (beep),
    .alarm            (alarm),
    .curtain_move     (curtain_move),
    .curtain_position (curtain_position)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Controller model: register copies and state latches.
  // Thresholds are kept as plain ints so sums and differences never wrap.
  // ---------------------------------------------------------------------------
  int          m_temp_on;
  int          m_temp_medium;
  int          m_temp_critical;
  int          m_temp_band;
  int          m_dark_level;
  int          m_light_band;
  int          m_smoke_limit;
  logic [31:0] m_beep_interval;

  logic        fan_latch;
  logic        led_latch;
  logic        alarm_latch;
  logic [31:0] last_beep;
  logic        curtain_pos;

  // Bookkeeping shared by the stimulus, driver and monitor processes.
  sample_t pending_samples[$];
  result_t expected_results[$];
  int      items_pushed;
  int      items_taken;
  int      mismatches;
  bit      idle_on;
  int      hold_requests;
  bit      in_accepted;
  bit      out_accepted;

  // Stimulus-side generator state.
  logic [31:0] tick_now;
  int          smoke_run;
  logic        curtain_now;

  initial begin
    m_temp_on       = int'(TEMP_ON_RESET);
    m_temp_medium   = int'(TEMP_MEDIUM_RESET);
    m_temp_critical = int'(TEMP_CRITICAL_RESET);
    m_temp_band     = int'(TEMP_BAND_RESET);
    m_dark_level    = int'(DARK_LEVEL_RESET);
    m_light_band    = int'(LIGHT_BAND_RESET);
    m_smoke_limit   = int'(SMOKE_LIMIT_RESET);
    m_beep_interval = BEEP_INTERVAL_RESET;
    fan_latch       = 1'b0;
    led_latch       = 1'b0;
    alarm_latch     = 1'b0;
    last_beep       = '0;
    curtain_pos     = 1'b0;
    items_pushed    = 0;
    items_taken     = 0;
    mismatches      = 0;
    idle_on         = 1'b1;
    hold_requests   = 0;
    in_accepted     = 1'b0;
    out_accepted    = 1'b0;
    tick_now        = '0;
    smoke_run       = 0;
    curtain_now     = 1'b0;
  end

  // Result of one accepted item; updates the latches as the block does.
  function automatic result_t controller_step(sample_t s);
    result_t     r;
    int          temp;
    int          lux;
    fan_level_t  lvl;
    logic        fan_on;
    logic        led_on;
    logic [7:0]  led_lvl;
    logic        do_beep;
    logic        do_move;
    logic [31:0] since_beep;
    temp    = int'(s.temperature);
    lux     = int'(s.light);
    lvl     = fan_level_t'(s.user_fan_level);
    fan_on  = s.user_fan_on;
    led_on  = s.user_led_on;
    led_lvl = s.user_led_level;
    do_beep = 1'b0;
    do_move = 1'b0;

    if (s.kind == KIND_SET_MODE) begin
      // resync hysteresis from the user's flags, manual mode leaves them alone
      if (s.auto_mode) begin
        fan_latch = fan_on;
        led_latch = led_on;
      end
    end else begin
      if (int'(s.smoke) > m_smoke_limit) begin
        since_beep = s.now_tick - last_beep;  // modulo 2^32
        if (!alarm_latch) begin
          alarm_latch = 1'b1;
          do_beep = 1'b1;
        end else if (since_beep >= m_beep_interval) begin
          do_beep = 1'b1;
        end
        if (do_beep) last_beep = s.now_tick;
        lvl       = FAN_HIGH;
        fan_on    = 1'b1;
        fan_latch = 1'b1;
      end else begin
        alarm_latch = 1'b0;
        if (s.auto_mode && AUTO_FAN_ON_DEFAULT) begin
          if (fan_latch) begin
            if (temp < m_temp_on - m_temp_band) begin
              lvl = FAN_OFF; fan_on = 1'b0; fan_latch = 1'b0;
            end else if (temp > m_temp_critical) begin
              lvl = FAN_HIGH; fan_on = 1'b1;
            end else if (temp > m_temp_medium) begin
              lvl = FAN_MEDIUM; fan_on = 1'b1;
            end else begin
              lvl = FAN_LOW; fan_on = 1'b1;
            end
          end else begin
            if (temp > m_temp_critical) begin
              lvl = FAN_HIGH; fan_on = 1'b1; fan_latch = 1'b1;
            end else if (temp > m_temp_medium) begin
              lvl = FAN_MEDIUM; fan_on = 1'b1; fan_latch = 1'b1;
            end else if (temp > m_temp_on) begin
              lvl = FAN_LOW; fan_on = 1'b1; fan_latch = 1'b1;
            end else begin
              lvl = FAN_OFF; fan_on = 1'b0;
            end
          end
        end
      end

      if (s.auto_mode && AUTO_LIGHT_ON_DEFAULT) begin
        if (led_latch) begin
          if (lux > m_dark_level + m_light_band) begin
            led_on = 1'b0; led_lvl = '0; led_latch = 1'b0;
          end
        end else if (lux < m_dark_level) begin
          led_on = 1'b1; led_lvl = 8'(LED_FULL_LEVEL_DEFAULT); led_latch = 1'b1;
        end
      end

      if (s.curtain_request != curtain_pos) begin
        do_move     = 1'b1;
        curtain_pos = s.curtain_request;
      end
    end

    if (!led_on) led_lvl = '0;

    r.fan_level        = lvl;
    r.fan_run          = fan_on;
    r.led_run          = led_on;
    r.led_level        = led_lvl;
    r.beep             = do_beep;
    r.alarm            = alarm_latch;
    r.curtain_move     = do_move;
    r.curtain_position = curtain_pos;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= val;
    case (idx)
      REG_TEMP_ON:       m_temp_on       = int'($signed(val[15:0]));
      REG_TEMP_MEDIUM:   m_temp_medium   = int'($signed(val[15:0]));
      REG_TEMP_CRITICAL: m_temp_critical = int'($signed(val[15:0]));
      REG_TEMP_BAND:     m_temp_band     = int'(val[14:0]);
      REG_DARK_LEVEL:    m_dark_level    = int'(val[15:0]);
      REG_LIGHT_BAND:    m_light_band    = int'(val[15:0]);
      REG_SMOKE_LIMIT:   m_smoke_limit   = int'(val[15:0]);
      REG_BEEP_INTERVAL: m_beep_interval = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  // Register set for each phase; covers reset values, both extremes, ordered and
  // scrambled thresholds, zero and tiny beep intervals.
  task automatic program_phase(int p);
    int          on_lvl;
    int          med_lvl;
    int          crit_lvl;
    int          band;
    int          dark;
    int          lband;
    int          smk;
    logic [31:0] interval;
    case (p)
      0, 6: begin
        on_lvl   = int'(TEMP_ON_RESET);
        med_lvl  = int'(TEMP_MEDIUM_RESET);
        crit_lvl = int'(TEMP_CRITICAL_RESET);
        band     = int'(TEMP_BAND_RESET);
        dark     = int'(DARK_LEVEL_RESET);
        lband    = int'(LIGHT_BAND_RESET);
        smk      = int'(SMOKE_LIMIT_RESET);
        interval = (p == 0) ? BEEP_INTERVAL_RESET : 32'd5;
      end
      1: begin  // everything at its floor, zero beep interval
        on_lvl = -32768; med_lvl = -32768; crit_lvl = -32768; band = 0;
        dark = 0; lband = 0; smk = 0; interval = '0;
      end
      2: begin  // everything at its ceiling
        on_lvl = 32767; med_lvl = 32767; crit_lvl = 32767; band = 32767;
        dark = 65535; lband = 65535; smk = 65535; interval = 32'hFFFF_FFFF;
      end
      4: begin  // unordered thresholds
        on_lvl   = int'($urandom_range(0, 65535)) - 32768;
        med_lvl  = int'($urandom_range(0, 65535)) - 32768;
        crit_lvl = int'($urandom_range(0, 65535)) - 32768;
        band     = $urandom_range(0, 32767);
        dark     = $urandom_range(0, 65535);
        lband    = $urandom_range(0, 65535);
        smk      = $urandom_range(0, 65535);
        interval = $urandom_range(0, 100);
      end
      5: begin  // widest hysteresis bands, sums past 16 bits
        on_lvl = -32768; med_lvl = 0; crit_lvl = 32767; band = 32767;
        dark = 65535; lband = 65535; smk = 65534; interval = 32'd1;
      end
      default: begin  // ordered random thresholds
        on_lvl   = int'($urandom_range(0, 8000)) - 2000;
        med_lvl  = on_lvl + int'($urandom_range(0, 1500));
        crit_lvl = med_lvl + int'($urandom_range(0, 1500));
        band     = $urandom_range(0, 1000);
        dark     = $urandom_range(50, 3000);
        lband    = $urandom_range(0, 500);
        smk      = $urandom_range(100, 60000);
        interval = (p == 3) ? 32'($urandom_range(1, 40)) : $urandom;
      end
    endcase
    write_reg(REG_TEMP_ON, 32'(on_lvl));
    write_reg(REG_TEMP_MEDIUM, 32'(med_lvl));
    write_reg(REG_TEMP_CRITICAL, 32'(crit_lvl));
    write_reg(REG_TEMP_BAND, 32'(band));
    write_reg(REG_DARK_LEVEL, 32'(dark));
    write_reg(REG_LIGHT_BAND, 32'(lband));
    write_reg(REG_SMOKE_LIMIT, 32'(smk));
    write_reg(REG_BEEP_INTERVAL, interval);
  endtask

  task automatic push_sample(sample_t s);
    pending_samples.push_back(s);
    items_pushed++;
  endtask

  function automatic sample_t make_sample(item_kind_t k, int temp, int lux, int smk,
                                          logic [31:0] tick, logic am, logic [1:0] fl,
                                          logic fo, logic lo, logic [7:0] ll, logic cr);
    sample_t s;
    s.kind            = k;
    s.temperature     = 16'(temp);
    s.light           = 16'(lux);
    s.smoke           = 16'(smk);
    s.now_tick        = tick;
    s.auto_mode       = am;
    s.user_fan_level  = fl;
    s.user_fan_on     = fo;
    s.user_led_on     = lo;
    s.user_led_level  = ll;
    s.curtain_request = cr;
    return s;
  endfunction

  // Directed items, written for the reset register values:
  // fan on above 7168, medium above 7680, high above 8960, off below 6656;
  // LED on below 100, off above 150; alarm above 2000; beep every 10000 ticks.
  task automatic push_directed();
    // fan and light edges, curtain toggling
    push_sample(make_sample(KIND_SAMPLE, 7168, 100, 0, 0, 1, 3, 1, 1, 255, 0));
    push_sample(make_sample(KIND_SAMPLE, 7169, 99, 0, 0, 1, 0, 0, 0, 0, 1));
    push_sample(make_sample(KIND_SAMPLE, 6656, 150, 0, 0, 1, 2, 0, 1, 17, 1));
    push_sample(make_sample(KIND_SAMPLE, 6655, 151, 0, 0, 1, 1, 1, 1, 99, 0));
    push_sample(make_sample(KIND_SAMPLE, 7681, 65535, 0, 0, 1, 0, 0, 0, 0, 0));
    push_sample(make_sample(KIND_SAMPLE, 8961, 0, 0, 0, 1, 0, 0, 0, 0, 1));
    push_sample(make_sample(KIND_SAMPLE, 8960, 0, 0, 0, 1, 0, 0, 0, 0, 1));
    push_sample(make_sample(KIND_SAMPLE, 32767, 65535, 0, 0, 1, 0, 0, 1, 8, 0));
    push_sample(make_sample(KIND_SAMPLE, -32768, 65535, 0, 0, 1, 3, 1, 1, 255, 0));
    // set mode: auto resyncs latches, manual changes nothing
    push_sample(make_sample(KIND_SET_MODE, 0, 0, 65535, 0, 1, 2, 1, 1, 128, 1));
    push_sample(make_sample(KIND_SET_MODE, 0, 0, 0, 0, 0, 1, 0, 0, 77, 0));
    push_sample(make_sample(KIND_SAMPLE, 0, 65535, 0, 0, 1, 0, 0, 0, 0, 0));
    // smoke: threshold, entry beep, interval, tick wrap
    push_sample(make_sample(KIND_SAMPLE, 0, 1000, 2000, 50, 1, 0, 0, 0, 0, 0));
    push_sample(make_sample(KIND_SAMPLE, 0, 1000, 2001, 100, 1, 0, 0, 0, 0, 0));
    push_sample(make_sample(KIND_SAMPLE, 0, 1000, 65535, 5000, 0, 1, 0, 0, 0, 1));
    push_sample(make_sample(KIND_SAMPLE, 0, 1000, 3000, 10099, 1, 0, 0, 0, 0, 1));
    push_sample(make_sample(KIND_SAMPLE, 0, 1000, 3000, 10100, 1, 0, 0, 0, 0, 1));
    push_sample(make_sample(KIND_SAMPLE, 0, 1000, 3000, 32'hFFFF_FFF0, 1, 0, 0, 0, 0, 1));
    push_sample(make_sample(KIND_SAMPLE, 0, 1000, 3000, 32'd9990, 1, 0, 0, 0, 0, 1));
    // smoke clears in manual mode; inconsistent manual fan settings pass through
    push_sample(make_sample(KIND_SAMPLE, 0, 1000, 0, 9995, 0, 2, 0, 0, 200, 1));
    push_sample(make_sample(KIND_SAMPLE, 0, 1000, 0, 9999, 0, 0, 1, 1, 0, 1));
    // fan latched by the smoke: stays low inside the band
    push_sample(make_sample(KIND_SAMPLE, 7000, 1000, 0, 0, 1, 0, 0, 0, 0, 1));
    // set mode ignores a curtain change, the next sample moves it
    push_sample(make_sample(KIND_SET_MODE, 7000, 1000, 0, 0, 1, 0, 0, 0, 0, 0));
    push_sample(make_sample(KIND_SAMPLE, 7000, 1000, 0, 0, 1, 0, 0, 0, 0, 0));
  endtask

  // Random item biased toward the current thresholds; alarm bursts and rising
  // ticks let the beep interval logic run, occasional full-range values hit all bits.
  function automatic sample_t random_sample();
    sample_t s;
    int      base;
    int      off;
    int      temp;
    int      lux;
    int      smk;
    int      step;
    s.kind           = ($urandom_range(0, 99) < 8) ? KIND_SET_MODE : KIND_SAMPLE;
    s.auto_mode      = ($urandom_range(0, 99) < 75);
    s.user_fan_level = 2'($urandom_range(0, 3));
    s.user_fan_on    = 1'($urandom_range(0, 1));
    s.user_led_on    = 1'($urandom_range(0, 1));
    s.user_led_level = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 30) curtain_now = ~curtain_now;
    s.curtain_request = curtain_now;

    off = $urandom_range(0, 8);
    case ($urandom_range(0, 5))
      0:       base = m_temp_on;
      1:       base = m_temp_medium;
      2:       base = m_temp_critical;
      3:       base = m_temp_on - m_temp_band;
      default: base = int'($urandom_range(0, 65535)) - 32768;
    endcase
    temp = base + off - 4;
    if (temp > 32767) temp = 32767;
    if (temp < -32768) temp = -32768;
    s.temperature = 16'(temp);

    off = $urandom_range(0, 6);
    case ($urandom_range(0, 3))
      0:       base = m_dark_level;
      1:       base = m_dark_level + m_light_band;
      default: base = $urandom_range(0, 65535);
    endcase
    lux = base + off - 3;
    if (lux > 65535) lux = 65535;
    if (lux < 0) lux = 0;
    s.light = 16'(lux);

    if (smoke_run == 0 && $urandom_range(0, 99) < 10) smoke_run = $urandom_range(1, 8);
    if (smoke_run > 0 && m_smoke_limit < 65535) begin
      smoke_run--;
      smk = ($urandom_range(0, 3) == 0) ? m_smoke_limit + 1
                                        : int'($urandom_range(m_smoke_limit + 1, 65535));
    end else begin
      smoke_run = 0;
      smk = ($urandom_range(0, 3) == 0) ? m_smoke_limit : int'($urandom_range(0, m_smoke_limit));
    end
    s.smoke = 16'(smk);

    if ($urandom_range(0, 99) < 5) begin
      tick_now = $urandom;
    end else begin
      step = (m_beep_interval != 0 && m_beep_interval < 2000) ? int'(m_beep_interval) : 3000;
      tick_now = tick_now + $urandom_range(0, step);
    end
    s.now_tick = tick_now;
    return s;
  endfunction

  // Sender pause: everything offered has been taken and answered.
  task automatic wait_drained();
    while (items_taken != items_pushed || expected_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      program_phase(p);
      idle_on = (p % 3) != 2;  // every third phase runs flat out
      if (p == 0) push_directed();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        if (p == 5 && i == RANDOM_ITEMS / 2) wait_drained();
        push_sample(random_sample());
      end
      // receiver backs off while the sender keeps offering items
      if (p == 3) hold_requests++;
      wait_drained();
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("hysteresis_fan_light_controller: match");
    end else begin
      $display("hysteresis_fan_light_controller: mismatch");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers pending items at the falling edge, holds each until taken,
  // then, unless flat out, waits a random number of cycles before the next one.
  // ---------------------------------------------------------------------------
  int in_gap = 0;

  always @(negedge clk) begin
    if (in_valid && !in_accepted) begin
      // keep the item and valid steady
    end else if (in_gap > 0) begin
      in_gap--;
      in_valid <= 1'b0;
    end else if (pending_samples.size() > 0) begin
      cur_item = pending_samples.pop_front();
      in_valid <= 1'b1;
      in_gap = idle_on ? $urandom_range(0, 9) : 0;
    end else begin
      in_valid <= 1'b0;
    end
    in_accepted = 1'b0;
  end

  // Receiver: random stall per result unless flat out, plus long hold-off on request.
  int out_stall = 0;
  int hold_served = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    if (out_accepted) out_stall = idle_on ? $urandom_range(0, 9) : 0;
    out_accepted = 1'b0;
    if (hold_served != hold_requests) begin
      hold_left = HOLD_CYCLES;
      hold_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each accepted input item, checks each accepted result
  // against the oldest prediction.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(controller_step(cur_item));
        items_taken++;
        in_accepted = 1'b1;
      end
      if (out_valid && out_ready) begin
        out_accepted = 1'b1;
        got = {fan_level, fan_run, led_run, led_level, beep, alarm, curtain_move,
               curtain_position};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= PRINT_CAP)
            $display("%0t: result item with none expected, expected nothing, got %h",
                     $time, got);
        end else begin
          want = expected_results.pop_front();
          check_field("fan_level", 32'(want.fan_level), 32'(got.fan_level));
          check_field("fan_run", 32'(want.fan_run), 32'(got.fan_run));
          check_field("led_run", 32'(want.led_run), 32'(got.led_run));
          check_field("led_level", 32'(want.led_level), 32'(got.led_level));
          check_field("beep", 32'(want.beep), 32'(got.beep));
          check_field("alarm", 32'(want.alarm), 32'(got.alarm));
          check_field("curtain_move", 32'(want.curtain_move), 32'(got.curtain_move));
          check_field("curtain_position", 32'(want.curtain_position),
                      32'(got.curtain_position));
        end
      end
    end
  end

  // Watchdog: too long without any handshake means the block is stuck.
  initial begin
    int stuck;
    stuck = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck = 0;
      else stuck++;
      if (stuck >= STUCK_LIMIT) break;
    end
    $display("hysteresis_fan_light_controller: mismatch");
    $finish;
  end

endmodule

[files.f]
src/hfl_pkg.sv
src/hysteresis_fan_light_controller.sv
test/tb.sv
